### hw/rtl/ffhbm_pkg.sv
// Shared types, constants and codes of the first-fit heap block manager.
// No dependencies; imported by the controller, the datapath and the top level.
package ffhbm_pkg;

  localparam int unsigned MAX_BLOCKS_DEF          = 256;
  localparam int unsigned HEADER_BYTES_DEF        = 16;
  localparam int unsigned PAGE_BYTES_DEF          = 4096;
  localparam int unsigned MIN_SPLIT_REMAINDER_DEF = 16;

  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned LIMIT_W = 25;
  localparam int unsigned REQ_W   = 25;
  localparam int unsigned ST_W    = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'h100_0000;
  localparam logic [LIMIT_W-1:0] OFFSET_SPAN = 25'h100_0000;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_BADADDR = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  // One block record: start offset, payload size, free mark.
  typedef struct packed {
    logic              free;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] start;
  } rec_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_I,
    OP_NEXT,
    OP_FIT_WR,
    OP_SH_RD,
    OP_SH_INS_WR,
    OP_TAIL_WR,
    OP_GROW,
    OP_FOUND,
    OP_RD_NEXT,
    OP_MERGE_NEXT,
    OP_SH_REM_WR,
    OP_REM_DONE,
    OP_RD_PREV,
    OP_MERGE_PREV,
    OP_WR_CUR,
    OP_DONE
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_INS_RD,
    S_INS_WR,
    S_GROW,
    S_NXT_RD,
    S_NXT_CHK,
    S_REMN_RD,
    S_REMN_WR,
    S_PRV_RD,
    S_PRV_CHK,
    S_REMP_RD,
    S_REMP_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e     op;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic zero;
    logic i_end;
    logic fit;
    logic split;
    logic match;
    logic next_exist;
    logic rd_free;
    logic has_prev;
    logic full;
    logic nospace;
    logic ins_more;
    logic rem_more;
    logic out_busy;
  } dp_stat_t;

endpackage

### hw/rtl/ffhbm_ctrl.sv
// Sequencing state machine of the heap block manager.
// Depends on ffhbm_pkg; drives the datapath only through dp_cmd_t and reads dp_stat_t.
module ffhbm_ctrl
  import ffhbm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e  state_q, state_d;
  status_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    cmd_o.op   = OP_NONE;
    cmd_o.status = st_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          st_d     = ST_OK;
          state_d  = S_START;
        end
      end
      S_START: begin
        if (stat_i.is_alloc && stat_i.zero) begin
          st_d    = ST_ZERO;
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (stat_i.i_end) begin
          if (stat_i.is_alloc) begin
            state_d = S_GROW;
          end else begin
            st_d    = ST_BADADDR;
            state_d = S_DONE;
          end
        end else begin
          cmd_o.op = OP_RD_I;
          state_d  = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (stat_i.is_alloc && stat_i.fit) begin
          cmd_o.op = OP_FIT_WR;
          state_d  = stat_i.split ? S_INS_RD : S_DONE;
        end else if (!stat_i.is_alloc && stat_i.match) begin
          cmd_o.op = OP_FOUND;
          state_d  = S_NXT_RD;
        end else begin
          cmd_o.op = OP_NEXT;
          state_d  = S_SCAN_RD;
        end
      end
      S_INS_RD: begin
        if (stat_i.ins_more) begin
          cmd_o.op = OP_SH_RD;
          state_d  = S_INS_WR;
        end else begin
          cmd_o.op = OP_TAIL_WR;
          state_d  = S_DONE;
        end
      end
      S_INS_WR: begin
        cmd_o.op = OP_SH_INS_WR;
        state_d  = S_INS_RD;
      end
      S_GROW: begin
        if (stat_i.full) begin
          st_d = ST_FULL;
        end else if (stat_i.nospace) begin
          st_d = ST_NOSPACE;
        end else begin
          cmd_o.op = OP_GROW;
        end
        state_d = S_DONE;
      end
      S_NXT_RD: begin
        if (stat_i.next_exist) begin
          cmd_o.op = OP_RD_NEXT;
          state_d  = S_NXT_CHK;
        end else begin
          state_d = S_PRV_RD;
        end
      end
      S_NXT_CHK: begin
        if (stat_i.rd_free) begin
          cmd_o.op = OP_MERGE_NEXT;
          state_d  = S_REMN_RD;
        end else begin
          state_d = S_PRV_RD;
        end
      end
      S_REMN_RD: begin
        if (stat_i.rem_more) begin
          cmd_o.op = OP_SH_RD;
          state_d  = S_REMN_WR;
        end else begin
          cmd_o.op = OP_REM_DONE;
          state_d  = S_PRV_RD;
        end
      end
      S_REMN_WR: begin
        cmd_o.op = OP_SH_REM_WR;
        state_d  = S_REMN_RD;
      end
      S_PRV_RD: begin
        if (stat_i.has_prev) begin
          cmd_o.op = OP_RD_PREV;
          state_d  = S_PRV_CHK;
        end else begin
          cmd_o.op = OP_WR_CUR;
          state_d  = S_DONE;
        end
      end
      S_PRV_CHK: begin
        if (stat_i.rd_free) begin
          cmd_o.op = OP_MERGE_PREV;
          state_d  = S_REMP_RD;
        end else begin
          cmd_o.op = OP_WR_CUR;
          state_d  = S_DONE;
        end
      end
      S_REMP_RD: begin
        if (stat_i.rem_more) begin
          cmd_o.op = OP_SH_RD;
          state_d  = S_REMP_WR;
        end else begin
          cmd_o.op = OP_REM_DONE;
          state_d  = S_DONE;
        end
      end
      S_REMP_WR: begin
        cmd_o.op = OP_SH_REM_WR;
        state_d  = S_REMP_RD;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_DONE;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/ffhbm_dp.sv
// Datapath of the heap block manager: record memory, counters, arithmetic, result register.
// Depends on ffhbm_pkg; executes one dp_cmd_t per cycle from ffhbm_ctrl.
module ffhbm_dp
  import ffhbm_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS          = MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES        = HEADER_BYTES_DEF,
  parameter int unsigned PAGE_BYTES          = PAGE_BYTES_DEF,
  parameter int unsigned MIN_SPLIT_REMAINDER = MIN_SPLIT_REMAINDER_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_stat_t           stat_o,
  input  logic               in_action_i,
  input  logic [REQ_W-1:0]   in_size_i,
  input  logic [ADDR_W-1:0]  in_paddr_i,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ADDR_W-1:0]  out_addr_o,
  output logic [ST_W-1:0]    out_status_o,
  output logic [$clog2(MAX_BLOCKS):0] count_o
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = IW + 1;
  localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCKS);
  localparam rec_t INIT_REC = '{free: 1'b1,
                                size: ADDR_W'(PAGE_BYTES - HEADER_BYTES),
                                start: '0};

  rec_t mem [MAX_BLOCKS];

  logic              act_q;
  logic [25:0]       size_q;
  logic [ADDR_W-1:0] paddr_q;
  logic [CW-1:0]     i_q, j_q, cnt_q;
  logic [LIMIT_W-1:0] ext_q, lim_q;
  rec_t              cur_q, tail_q, rd_raw_q;
  logic              rd_init_q, init0_q;
  logic [ADDR_W-1:0] res_addr_q, out_addr_q;
  logic              out_valid_q;
  logic [ST_W-1:0]   out_st_q;

  rec_t              rd, wdata;
  logic              we, re;
  logic [IW-1:0]     waddr, raddr;
  logic [25:0]       size_rnd;
  logic [26:0]       need;
  logic [27:0]       grow;
  logic [LIMIT_W-1:0] lim_eff;

  assign rd       = rd_init_q ? INIT_REC : rd_raw_q;
  assign size_rnd = {1'b0, in_size_i} + 26'd3;
  assign need     = {1'b0, size_q} + 27'(HEADER_BYTES);
  // Page rounding by mask: the page size is a power of two.
  assign grow     = ({1'b0, need} + 28'(PAGE_BYTES - 1)) & ~28'(PAGE_BYTES - 1);
  assign lim_eff  = (lim_q > OFFSET_SPAN) ? OFFSET_SPAN : lim_q;

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = rd;
    unique case (cmd_i.op)
      OP_RD_I: begin
        re = 1'b1; raddr = i_q[IW-1:0];
      end
      OP_SH_RD: begin
        re = 1'b1; raddr = j_q[IW-1:0];
      end
      OP_RD_NEXT: begin
        re = 1'b1; raddr = IW'(i_q + CW'(1));
      end
      OP_RD_PREV: begin
        re = 1'b1; raddr = IW'(i_q - CW'(1));
      end
      OP_FIT_WR: begin
        we    = 1'b1;
        waddr = i_q[IW-1:0];
        wdata = '{free: 1'b0,
                  size: stat_o.split ? size_q[ADDR_W-1:0] : rd.size,
                  start: rd.start};
      end
      OP_SH_INS_WR: begin
        we = 1'b1; waddr = IW'(j_q + CW'(1)); wdata = rd;
      end
      OP_TAIL_WR: begin
        we = 1'b1; waddr = IW'(i_q + CW'(1)); wdata = tail_q;
      end
      OP_GROW: begin
        we    = 1'b1;
        waddr = cnt_q[IW-1:0];
        wdata = '{free: 1'b0, size: ADDR_W'(grow - 28'(HEADER_BYTES)),
                  start: ext_q[ADDR_W-1:0]};
      end
      OP_SH_REM_WR: begin
        we = 1'b1; waddr = IW'(j_q - CW'(1)); wdata = rd;
      end
      OP_MERGE_PREV: begin
        we    = 1'b1;
        waddr = IW'(i_q - CW'(1));
        wdata = '{free: 1'b1,
                  size: rd.size + ADDR_W'(HEADER_BYTES) + cur_q.size,
                  start: rd.start};
      end
      OP_WR_CUR: begin
        we = 1'b1; waddr = i_q[IW-1:0]; wdata = cur_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_raw_q <= mem[raddr];
    end
  end

  // Record zero holds its reset value until first written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init0_q   <= 1'b1;
      rd_init_q <= 1'b0;
    end else begin
      if (we && waddr == '0) begin
        init0_q <= 1'b0;
      end
      if (re) begin
        rd_init_q <= init0_q && (raddr == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= CW'(1);
      ext_q       <= LIMIT_W'(PAGE_BYTES);
      lim_q       <= LIMIT_RESET;
      i_q         <= '0;
      j_q         <= '0;
      act_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lim_q <= cfg_data_i;
      end
      // A finishing request loads the result register; otherwise a taken result empties it.
      if (cmd_i.op == OP_DONE) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_LOAD: begin
          act_q <= in_action_i;
          i_q   <= '0;
        end
        OP_NEXT:       i_q <= i_q + CW'(1);
        OP_FIT_WR:     j_q <= cnt_q - CW'(1);
        OP_SH_INS_WR:  j_q <= j_q - CW'(1);
        OP_TAIL_WR:    cnt_q <= cnt_q + CW'(1);
        OP_GROW: begin
          cnt_q <= cnt_q + CW'(1);
          ext_q <= LIMIT_W'({3'b0, ext_q} + grow);
        end
        OP_MERGE_NEXT: j_q <= i_q + CW'(2);
        OP_SH_REM_WR:  j_q <= j_q + CW'(1);
        OP_REM_DONE:   cnt_q <= cnt_q - CW'(1);
        OP_MERGE_PREV: j_q <= i_q + CW'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        size_q     <= {size_rnd[25:2], 2'b00};
        paddr_q    <= in_paddr_i;
        res_addr_q <= '0;
      end
      OP_FIT_WR: begin
        res_addr_q   <= rd.start + ADDR_W'(HEADER_BYTES);
        tail_q.free  <= 1'b1;
        tail_q.size  <= ADDR_W'({2'b0, rd.size} - size_q - 26'(HEADER_BYTES));
        tail_q.start <= ADDR_W'({2'b0, rd.start} + size_q + 26'(HEADER_BYTES));
      end
      OP_GROW:       res_addr_q <= ADDR_W'(ext_q + LIMIT_W'(HEADER_BYTES));
      OP_FOUND:      cur_q <= '{free: 1'b1, size: rd.size, start: rd.start};
      OP_MERGE_NEXT: cur_q.size <= cur_q.size + ADDR_W'(HEADER_BYTES) + rd.size;
      OP_DONE: begin
        out_addr_q <= res_addr_q;
        out_st_q   <= cmd_i.status;
      end
      default: begin
      end
    endcase
  end

  assign stat_o.is_alloc   = !act_q;
  assign stat_o.zero       = (size_q == '0);
  assign stat_o.i_end      = (i_q == cnt_q);
  assign stat_o.fit        = rd.free && ({2'b0, rd.size} >= size_q);
  assign stat_o.split      = ({3'b0, rd.size} >=
                              {1'b0, size_q} + 27'(HEADER_BYTES + MIN_SPLIT_REMAINDER))
                             && (cnt_q < MAXB);
  assign stat_o.match      = ({1'b0, rd.start} + 25'(HEADER_BYTES)) == {1'b0, paddr_q};
  assign stat_o.next_exist = (i_q + CW'(1)) < cnt_q;
  assign stat_o.rd_free    = rd.free;
  assign stat_o.has_prev   = (i_q != '0);
  assign stat_o.full       = (cnt_q >= MAXB);
  assign stat_o.nospace    = ({3'b0, ext_q} + grow) > {3'b0, lim_eff};
  assign stat_o.ins_more   = (j_q > i_q);
  assign stat_o.rem_more   = (j_q < cnt_q);
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_addr_o   = out_addr_q;
  assign out_status_o = out_st_q;
  assign count_o      = cnt_q;

endmodule

### hw/rtl/first_fit_heap_block_manager_unit.sv
// Top level of the first-fit heap block manager with coalescing.
// Depends on ffhbm_pkg, ffhbm_ctrl and ffhbm_dp.
//
//   Channel  Direction  Moves                                   Handshake
//   s_axis   in         one request: allocate or free           s_axis_tvalid/tready
//   m_axis   out        one result per request                  m_axis_tvalid/tready
//   cfg      in         heap_limit register write               cfg_valid_i/cfg_ready_o
//
// A request reads and then checks each block record visited by the first-fit or address
// search, and reads and then writes each record moved when a split inserts or a merge
// removes a record, with setup and result steps around them.
// After reset the table holds one free block covering the first page; no clearing pass is
// needed. The next request is accepted once the current one is finished, even while its
// result still waits in the output register. A stalled output only holds the finishing
// step of a following request.
module first_fit_heap_block_manager_unit
  import ffhbm_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS          = MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES        = HEADER_BYTES_DEF,
  // Must be a power of two.
  parameter int unsigned PAGE_BYTES          = PAGE_BYTES_DEF,
  parameter int unsigned MIN_SPLIT_REMAINDER = MIN_SPLIT_REMAINDER_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // Bits from 0: request_size[24:0], payload_address[48:25], zero fill [55:49].
  input  logic [55:0]        s_axis_tdata,
  // Bit 0: action (0 allocate, 1 free).
  input  logic               s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // Bits from 0: result_address[23:0], status[26:24], zero fill [31:27].
  output logic [31:0]        m_axis_tdata,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LIMIT_W-1:0] cfg_data_i
);

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic [ADDR_W-1:0]   out_addr;
  logic [ST_W-1:0]     out_status;
  logic [$clog2(MAX_BLOCKS):0] count;

  // The limit register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  ffhbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ffhbm_dp #(
    .MAX_BLOCKS          (MAX_BLOCKS),
    .HEADER_BYTES        (HEADER_BYTES),
    .PAGE_BYTES          (PAGE_BYTES),
    .MIN_SPLIT_REMAINDER (MIN_SPLIT_REMAINDER)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_action_i  (s_axis_tuser),
    .in_size_i    (s_axis_tdata[24:0]),
    .in_paddr_i   (s_axis_tdata[48:25]),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_addr_o   (out_addr),
    .out_status_o (out_status),
    .count_o      (count)
  );

  assign m_axis_tdata = {5'b0, out_status, out_addr};

  // The record table never empties and never overflows.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count != '0) && (count <= ($clog2(MAX_BLOCKS)+1)'(MAX_BLOCKS)))
    else $error("record count out of range");

  // A failed request or a free never returns an address.
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_status != ST_OK) |-> (out_addr == '0))
    else $error("address returned with error status");

  // Only defined status codes leave the block.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_status <= ST_FULL))
    else $error("undefined status code");

  // One request at a time: a taken request closes the input until it finishes.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while busy");

endmodule

### tb/first_fit_heap_block_manager_unit_checker.sv
// Checker for the first-fit heap block manager. It watches the request, result and
// configuration channels, predicts each result, and counts mismatches. Depends on ffhbm_pkg.
module first_fit_heap_block_manager_unit_checker
  import ffhbm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [55:0]        s_axis_tdata,
  input  logic               s_axis_tuser,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [31:0]        m_axis_tdata,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [LIMIT_W-1:0] cfg_data_i,
  output int                 fail_count,
  output int                 pending
);

  localparam int NREC = MAX_BLOCKS_DEF;
  localparam int HDR  = HEADER_BYTES_DEF;
  localparam int PAGE = PAGE_BYTES_DEF;
  localparam int MINR = MIN_SPLIT_REMAINDER_DEF;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_e           status;
  } heap_result_t;

  logic [ADDR_W-1:0]  blk_start [NREC];
  logic [ADDR_W-1:0]  blk_size  [NREC];
  bit                 blk_free  [NREC];
  int                 blk_count;
  logic [LIMIT_W-1:0] heap_extent;
  logic [LIMIT_W-1:0] heap_limit;
  heap_result_t       expected_results [$];

  assign pending = expected_results.size();

  function automatic void insert_block(int pos, logic [ADDR_W-1:0] st, logic [ADDR_W-1:0] sz,
                                       bit fr);
    for (int k = blk_count; k > pos; k--) begin
      blk_start[k] = blk_start[k-1];
      blk_size[k]  = blk_size[k-1];
      blk_free[k]  = blk_free[k-1];
    end
    blk_start[pos] = st;
    blk_size[pos]  = sz;
    blk_free[pos]  = fr;
    blk_count++;
  endfunction

  function automatic void remove_block(int pos);
    for (int k = pos; k < blk_count - 1; k++) begin
      blk_start[k] = blk_start[k+1];
      blk_size[k]  = blk_size[k+1];
      blk_free[k]  = blk_free[k+1];
    end
    blk_count--;
  endfunction

  function automatic heap_result_t allocate_block(logic [REQ_W-1:0] req);
    heap_result_t res;
    longint rounded, grow, lim;
    res.addr   = '0;
    res.status = ST_OK;
    if (req == 0) begin
      res.status = ST_ZERO;
      return res;
    end
    rounded = (longint'(req) + 3) & ~longint'(3);
    for (int i = 0; i < blk_count; i++) begin
      if (blk_free[i] && longint'(blk_size[i]) >= rounded) begin
        blk_free[i] = 1'b0;
        if (longint'(blk_size[i]) >= rounded + HDR + MINR && blk_count < NREC) begin
          insert_block(i + 1, ADDR_W'(blk_start[i] + HDR + rounded),
                       ADDR_W'(blk_size[i] - rounded - HDR), 1'b1);
          blk_size[i] = ADDR_W'(rounded);
        end
        res.addr = ADDR_W'(blk_start[i] + HDR);
        return res;
      end
    end
    if (blk_count >= NREC) begin
      res.status = ST_FULL;
      return res;
    end
    grow = ((rounded + HDR + PAGE - 1) / PAGE) * PAGE;
    lim  = (heap_limit > OFFSET_SPAN) ? longint'(OFFSET_SPAN) : longint'(heap_limit);
    if (longint'(heap_extent) + grow > lim) begin
      res.status = ST_NOSPACE;
      return res;
    end
    insert_block(blk_count, ADDR_W'(heap_extent), ADDR_W'(grow - HDR), 1'b0);
    res.addr    = ADDR_W'(heap_extent + HDR);
    heap_extent = LIMIT_W'(longint'(heap_extent) + grow);
    return res;
  endfunction

  function automatic heap_result_t free_block(logic [ADDR_W-1:0] paddr);
    heap_result_t res;
    int i;
    res.addr   = '0;
    res.status = ST_OK;
    i = 0;
    while (i < blk_count && longint'(blk_start[i]) + HDR != longint'(paddr)) i++;
    if (i >= blk_count) begin
      res.status = ST_BADADDR;
      return res;
    end
    blk_free[i] = 1'b1;
    // Merge with the following block first, then with the preceding one.
    if (i + 1 < blk_count && blk_free[i+1]) begin
      blk_size[i] = ADDR_W'(blk_size[i] + HDR + blk_size[i+1]);
      remove_block(i + 1);
    end
    if (i > 0 && blk_free[i-1]) begin
      blk_size[i-1] = ADDR_W'(blk_size[i-1] + HDR + blk_size[i]);
      remove_block(i);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t got, want;
    if (!rst_ni) begin
      blk_start[0] = '0;
      blk_size[0]  = ADDR_W'(PAGE - HDR);
      blk_free[0]  = 1'b1;
      blk_count    = 1;
      heap_extent  = LIMIT_W'(PAGE);
      heap_limit   = LIMIT_RESET;
      expected_results.delete();
      fail_count   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) heap_limit = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) expected_results.push_back(free_block(s_axis_tdata[48:25]));
        else expected_results.push_back(allocate_block(s_axis_tdata[24:0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.addr   = m_axis_tdata[23:0];
        got.status = status_e'(m_axis_tdata[26:24]);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result addr=%h status=%0d", $time, got.addr,
                   got.status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     got.status);
            fail_count++;
          end
          if (got.addr !== want.addr) begin
            $display("%0t: address expected %h actual %h", $time, want.addr, got.addr);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

### tb/first_fit_heap_block_manager_unit_tb.sv
// Testbench top for the first-fit heap block manager: clock, reset, stimulus and verdict.
// Depends on ffhbm_pkg, the block itself and first_fit_heap_block_manager_unit_checker.
module first_fit_heap_block_manager_unit_tb;
  import ffhbm_pkg::*;

  localparam int CYCLE_LIMIT = 20_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [55:0]        s_axis_tdata = '0;
  logic               s_axis_tuser = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [LIMIT_W-1:0] cfg_data_i = '0;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;

  // Payload offsets handed out so far; frees are drawn mostly from here.
  logic [ADDR_W-1:0]  live_addrs [$];
  logic [ADDR_W-1:0]  last_freed = '0;
  int                 status_seen [5] = '{default: 0};

  always #6 clk_i = ~clk_i;

  first_fit_heap_block_manager_unit dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  first_fit_heap_block_manager_unit_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .fail_count, .pending
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[first_fit_heap_block_manager_unit] ERROR");
      $finish;
    end
  end

  // Learn the offsets of successful allocations so that frees can hit real blocks.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      status_seen[m_axis_tdata[26:24] % 5]++;
      if (m_axis_tdata[26:24] == ST_OK && m_axis_tdata[23:0] != 0 && live_addrs.size() < 600)
        live_addrs.push_back(m_axis_tdata[23:0]);
    end
  end

  // The receiver stalls on its own pattern: stretches of always ready, of coin flips and of
  // rare acceptance. Once, well into the run, it refuses results for a long stretch while
  // the sender keeps offering requests, so the output register fills and input stalls.
  initial begin
    int mode, len;
    bit long_hold_done;
    long_hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!long_hold_done && cycle_count > 30000) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (2000) @(posedge clk_i);
      end
      mode = $urandom_range(2);
      len  = $urandom_range(200, 20);
      repeat (len) begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(1);
          default: m_axis_tready <= ($urandom_range(4) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Offer one request and hold it until the block takes it. Valid stays high on return so
  // the next request can follow back to back.
  task automatic send_request(bit is_free, logic [REQ_W-1:0] req_size,
                              logic [ADDR_W-1:0] paddr);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= is_free;
    s_axis_tdata  <= {7'b0, paddr, req_size};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_sender(int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Wait until every expected result has come back, plus a short settling time.
  task automatic drain_results();
    idle_sender(1);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_heap_limit(logic [LIMIT_W-1:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // One random request. Small sizes dominate so the record table fills and splits happen
  // often; frees mostly target live blocks, with double frees and junk addresses mixed in.
  task automatic random_request();
    int pick, slot;
    logic [REQ_W-1:0] req_size;
    logic [ADDR_W-1:0] paddr;
    pick = $urandom_range(99);
    if (pick < 55) begin
      pick = $urandom_range(99);
      if (pick < 70) req_size = $urandom_range(64, 1);
      else if (pick < 90) req_size = $urandom_range(3000, 65);
      else if (pick < 97) req_size = $urandom_range(20000, 3001);
      else if (pick < 98) req_size = '0;
      else if (pick < 99) req_size = $urandom_range(REQ_W'(OFFSET_SPAN), 0);
      else req_size = OFFSET_SPAN;
      send_request(1'b0, req_size, ADDR_W'($urandom));
    end else begin
      pick = $urandom_range(99);
      if (pick < 75 && live_addrs.size() > 0) begin
        slot = $urandom_range(live_addrs.size() - 1);
        paddr = live_addrs[slot];
        live_addrs.delete(slot);
        last_freed = paddr;
      end else if (pick < 85) begin
        paddr = last_freed;
      end else if (pick < 93) begin
        paddr = ADDR_W'($urandom);
      end else begin
        paddr = ADDR_W'($urandom_range(8191) & ~3);
      end
      send_request(1'b1, REQ_W'($urandom), paddr);
    end
  endtask

  // Random requests in bursts of random length with random gaps; some gaps are zero.
  task automatic random_phase(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      repeat ($urandom_range(20, 1)) begin
        if (sent < count) begin
          random_request();
          sent++;
        end
      end
      if ($urandom_range(3) != 0) idle_sender($urandom_range(10));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: zero size, exact fit, split, growth, oversize, bad and double frees.
    send_request(1'b0, '0, '0);
    send_request(1'b0, 25'd4080, '0);           // whole first block, no split
    send_request(1'b1, '1, 24'd16);             // free it again
    send_request(1'b1, '0, 24'd16);             // double free
    send_request(1'b1, '0, 24'd0);              // offset 0 is never a payload
    send_request(1'b1, '0, 24'hFFFFFF);
    send_request(1'b0, 25'd1, 24'hFFFFFF);      // splits the first block
    send_request(1'b0, 25'd4049, '0);           // rounds to 4052: too small a tail to split
    send_request(1'b0, 25'd5000, '0);           // grows by two pages
    send_request(1'b0, OFFSET_SPAN, '0);        // never fits
    send_request(1'b0, 25'hFFFFFF, '0);
    send_request(1'b1, '0, 24'd16);
    send_request(1'b1, '0, 24'd4096 + 24'd16);  // no free neighbour, so nothing merges
    send_request(1'b1, '0, 24'd4096 + 24'd16);  // double free: the block is still there
    send_request(1'b0, 25'd8, '0);
    send_request(1'b0, 25'd2, '0);

    // A low limit: growth fails at once, later stays refused.
    write_heap_limit(25'd4096);
    send_request(1'b0, 25'd4096, '0);
    send_request(1'b0, 25'd3, '0);
    random_phase(300);

    // Above the offset span: acts as the full span.
    write_heap_limit('1);
    random_phase(600);

    write_heap_limit(LIMIT_W'($urandom_range(OFFSET_SPAN, 4096)));
    random_phase(500);

    write_heap_limit(25'd65536);
    random_phase(600);

    drain_results();
    $display("Requests covered allocate and free under four heap limits; results seen:");
    $display("  ok %0d, zero size %0d, no space %0d, bad address %0d, table full %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (fail_count == 0) begin
      $display("[first_fit_heap_block_manager_unit] OK");
    end else begin
      $display("[first_fit_heap_block_manager_unit] ERROR");
    end
    $finish;
  end

endmodule
